// ===== design/rau_pkg.sv =====
package rau_pkg;

	// arithmetic word
	localparam int WORD_BITS = 64;
	localparam logic [WORD_BITS-1:0] HALF_W = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam logic [WORD_BITS-1:0] MAX_POS = {1'b0, {(WORD_BITS-1){1'b1}}};

	// opcodes
	localparam logic [2:0] CMD_NORM = 3'd0;
	localparam logic [2:0] CMD_ADD  = 3'd1;
	localparam logic [2:0] CMD_SUB  = 3'd2;
	localparam logic [2:0] CMD_MUL  = 3'd3;
	localparam logic [2:0] CMD_DIV  = 3'd4;
	localparam logic [2:0] CMD_NEG  = 3'd5;
	localparam logic [2:0] CMD_ABS  = 3'd6;
	localparam logic [2:0] CMD_CMP  = 3'd7;

	// request to the multiply/divide unit
	typedef struct packed {
		logic                 start;
		logic                 div;
		logic [WORD_BITS-1:0] x;
		logic [WORD_BITS-1:0] y;
	} rau_req_t;

	// answer from the multiply/divide unit
	typedef struct packed {
		logic                 done;
		logic [WORD_BITS-1:0] val;
		logic [WORD_BITS-1:0] rem;
		logic                 mof;
	} rau_rsp_t;

	// finished result word
	typedef struct packed {
		logic [WORD_BITS-1:0] num;
		logic [WORD_BITS-2:0] den;
		logic                 less;
		logic                 equal;
		logic                 bad;
		logic                 ovf;
	} rau_res_t;

	// sign-magnitude value fits the signed word
	function automatic logic fits(input logic neg, input logic [WORD_BITS-1:0] mag);
		fits = neg ? (mag <= HALF_W) : (mag <= MAX_POS);
	endfunction

endpackage

// ===== design/rau_mdu.sv =====
module rau_mdu (
	input  logic           clk,
	input  logic           arst_n,
	input  rau_pkg::rau_req_t req,
	output rau_pkg::rau_rsp_t rsp
);

	localparam int W = rau_pkg::WORD_BITS;
	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          div_q;
	logic          done_q;
	logic          mof_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  a_q;
	logic [W-1:0]  s_q;
	logic [W-1:0]  acc_q;

	logic [W:0]    mul_sum;
	logic [W:0]    rem_sh;
	logic [W:0]    rem_diff;
	logic          ge;

	// one bit a cycle: shift-add multiply or restoring divide
	always_comb begin
		mul_sum  = {1'b0, acc_q[W-2:0], 1'b0} + (s_q[W-1] ? {1'b0, a_q} : '0);
		rem_sh   = {acc_q, s_q[W-1]};
		rem_diff = rem_sh - {1'b0, a_q};
		ge       = rem_sh >= {1'b0, a_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.div;
			mof_q <= 1'b0;
			acc_q <= '0;
			a_q   <= req.div ? req.y : req.x;
			s_q   <= req.div ? req.x : req.y;
		end else if (busy_q) begin
			if (div_q) begin
				s_q   <= {s_q[W-2:0], ge};
				acc_q <= ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
			end else begin
				s_q   <= {s_q[W-2:0], 1'b0};
				acc_q <= mul_sum[W-1:0];
				mof_q <= mof_q | acc_q[W-1] | mul_sum[W];
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.val  = div_q ? s_q : acc_q;
	assign rsp.rem  = acc_q;
	assign rsp.mof  = mof_q;

endmodule

// ===== design/rau_seq.sv =====
module rau_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [2:0]                    cmd,
	input  logic [rau_pkg::WORD_BITS-1:0] a_num,
	input  logic [rau_pkg::WORD_BITS-1:0] a_den,
	input  logic [rau_pkg::WORD_BITS-1:0] b_num,
	input  logic [rau_pkg::WORD_BITS-1:0] b_den,
	input  logic                          take,
	input  rau_pkg::rau_rsp_t             rsp,
	output rau_pkg::rau_req_t             req,
	output logic                          busy,
	output logic                          fin,
	output rau_pkg::rau_res_t             res
);

	localparam int W = rau_pkg::WORD_BITS;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_DEC   = 5'd1;
	localparam logic [4:0] S_RED   = 5'd2;
	localparam logic [4:0] S_GCD   = 5'd3;
	localparam logic [4:0] S_GCD2  = 5'd4;
	localparam logic [4:0] S_REDN  = 5'd5;
	localparam logic [4:0] S_REDN2 = 5'd6;
	localparam logic [4:0] S_REDD2 = 5'd7;
	localparam logic [4:0] S_WAIT  = 5'd8;
	localparam logic [4:0] S_RA    = 5'd9;
	localparam logic [4:0] S_RB    = 5'd10;
	localparam logic [4:0] S_OP    = 5'd11;
	localparam logic [4:0] S_AS1   = 5'd12;
	localparam logic [4:0] S_AS2   = 5'd13;
	localparam logic [4:0] S_AS3   = 5'd14;
	localparam logic [4:0] S_AS4   = 5'd15;
	localparam logic [4:0] S_AS5   = 5'd16;
	localparam logic [4:0] S_AS6   = 5'd17;
	localparam logic [4:0] S_AS7   = 5'd18;
	localparam logic [4:0] S_M1    = 5'd19;
	localparam logic [4:0] S_M2    = 5'd20;
	localparam logic [4:0] S_D1    = 5'd21;
	localparam logic [4:0] S_D2    = 5'd22;
	localparam logic [4:0] S_C1    = 5'd23;
	localparam logic [4:0] S_C2    = 5'd24;
	localparam logic [4:0] S_FIN   = 5'd25;

	logic [4:0]   state_q, alu_ret_q, gcd_ret_q, red_ret_q;
	logic [2:0]   cmd_q;
	logic [W-1:0] ra_num_q, ra_den_q, rb_num_q, rb_den_q;
	logic         an_neg_q, bn_neg_q, rn_neg_q, rd_neg_q, x_neg_q;
	logic [W-1:0] an_mag_q, ad_q, bn_mag_q, bd_q, rn_mag_q, rd_mag_q;
	logic [W-1:0] gx_q, gy_q, lcm_q, x_mag_q;
	logic         bad_q, ovf_q, less_q, equal_q;
	rau_pkg::rau_req_t req_q;

	logic         binary;
	logic         a_neg_raw, b_neg_raw, ad_neg_raw, bd_neg_raw;
	logic [W-1:0] a_mag_raw, b_mag_raw, ad_mag_raw, bd_mag_raw;
	logic [W-1:0] prod;
	logic         prod_nz, fit_pos, fit_neg;
	logic         tb_neg;
	logic [W:0]   sum_add;
	logic [W-1:0] sum_mag;
	logic         sum_neg, sum_ok;
	logic         cmp_less;

	// operand decode and sign handling
	always_comb begin
		binary     = (cmd_q != rau_pkg::CMD_NORM) && (cmd_q != rau_pkg::CMD_NEG)
			&& (cmd_q != rau_pkg::CMD_ABS);
		a_neg_raw  = ra_num_q[W-1];
		ad_neg_raw = ra_den_q[W-1];
		b_neg_raw  = rb_num_q[W-1];
		bd_neg_raw = rb_den_q[W-1];
		a_mag_raw  = a_neg_raw ? (~ra_num_q + 1'b1) : ra_num_q;
		ad_mag_raw = ad_neg_raw ? (~ra_den_q + 1'b1) : ra_den_q;
		b_mag_raw  = b_neg_raw ? (~rb_num_q + 1'b1) : rb_num_q;
		bd_mag_raw = bd_neg_raw ? (~rb_den_q + 1'b1) : rb_den_q;
		prod       = rsp.val;
		prod_nz    = prod != '0;
		fit_pos    = !rsp.mof && rau_pkg::fits(1'b0, prod);
		fit_neg    = !rsp.mof && rau_pkg::fits(1'b1, prod);
	end

	// signed add of the two scaled terms
	always_comb begin
		tb_neg  = (bn_neg_q ^ (cmd_q == rau_pkg::CMD_SUB)) && prod_nz;
		sum_add = '0;
		sum_mag = '0;
		sum_neg = 1'b0;
		if (x_neg_q == tb_neg) begin
			sum_add = {1'b0, x_mag_q} + {1'b0, prod};
			sum_mag = sum_add[W-1:0];
			sum_neg = x_neg_q;
		end else if (x_mag_q >= prod) begin
			sum_mag = x_mag_q - prod;
			sum_neg = x_neg_q;
		end else begin
			sum_mag = prod - x_mag_q;
			sum_neg = tb_neg;
		end
		sum_neg = sum_neg && (sum_mag != '0);
		sum_ok  = !sum_add[W] && rau_pkg::fits(sum_neg, sum_mag);
	end

	// less-than between cross products x and current product
	always_comb begin
		if (x_neg_q != (bn_neg_q && prod_nz))
			cmp_less = x_neg_q;
		else if (x_neg_q)
			cmp_less = x_mag_q > prod;
		else
			cmp_less = x_mag_q < prod;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q.start <= 1'b0;
		end else begin
			req_q.start <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_DEC;
				end
				S_DEC: begin
					bad_q   <= (ad_mag_raw == '0) || (binary && bd_mag_raw == '0);
					ovf_q   <= 1'b0;
					less_q  <= 1'b0;
					equal_q <= 1'b0;
					if ((ad_mag_raw == '0) || (binary && bd_mag_raw == '0)) begin
						state_q <= S_FIN;
					end else begin
						rn_neg_q  <= a_neg_raw;
						rn_mag_q  <= a_mag_raw;
						rd_neg_q  <= ad_neg_raw;
						rd_mag_q  <= ad_mag_raw;
						red_ret_q <= S_RA;
						state_q   <= S_RED;
					end
				end
				S_RED: begin
					gx_q      <= rn_mag_q;
					gy_q      <= rd_mag_q;
					gcd_ret_q <= S_REDN;
					state_q   <= S_GCD;
				end
				S_GCD: begin
					if (gy_q == '0) begin
						state_q <= gcd_ret_q;
					end else begin
						req_q     <= '{start: 1'b1, div: 1'b1, x: gx_q, y: gy_q};
						alu_ret_q <= S_GCD2;
						state_q   <= S_WAIT;
					end
				end
				S_GCD2: begin
					gx_q    <= gy_q;
					gy_q    <= rsp.rem;
					state_q <= S_GCD;
				end
				S_REDN: begin
					req_q     <= '{start: 1'b1, div: 1'b1, x: rn_mag_q, y: gx_q};
					alu_ret_q <= S_REDN2;
					state_q   <= S_WAIT;
				end
				S_REDN2: begin
					rn_mag_q  <= prod;
					req_q     <= '{start: 1'b1, div: 1'b1, x: rd_mag_q, y: gx_q};
					alu_ret_q <= S_REDD2;
					state_q   <= S_WAIT;
				end
				S_REDD2: begin
					rd_mag_q <= prod;
					rn_neg_q <= (rn_neg_q ^ rd_neg_q) && (rn_mag_q != '0);
					if (!rau_pkg::fits((rn_neg_q ^ rd_neg_q) && (rn_mag_q != '0), rn_mag_q)
						|| !rau_pkg::fits(1'b0, prod)) begin
						ovf_q   <= 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= red_ret_q;
					end
				end
				S_WAIT: begin
					if (rsp.done) state_q <= alu_ret_q;
				end
				S_RA: begin
					an_neg_q <= rn_neg_q;
					an_mag_q <= rn_mag_q;
					ad_q     <= rd_mag_q;
					if (binary) begin
						rn_neg_q  <= b_neg_raw;
						rn_mag_q  <= b_mag_raw;
						rd_neg_q  <= bd_neg_raw;
						rd_mag_q  <= bd_mag_raw;
						red_ret_q <= S_RB;
						state_q   <= S_RED;
					end else begin
						state_q <= S_OP;
					end
				end
				S_RB: begin
					bn_neg_q <= rn_neg_q;
					bn_mag_q <= rn_mag_q;
					bd_q     <= rd_mag_q;
					state_q  <= S_OP;
				end
				S_OP: begin
					case (cmd_q)
						rau_pkg::CMD_NORM: begin
							rn_neg_q <= an_neg_q;
							rn_mag_q <= an_mag_q;
							rd_mag_q <= ad_q;
							state_q  <= S_FIN;
						end
						rau_pkg::CMD_NEG: begin
							rn_neg_q <= !an_neg_q && (an_mag_q != '0);
							rn_mag_q <= an_mag_q;
							rd_mag_q <= ad_q;
							ovf_q    <= !rau_pkg::fits(!an_neg_q && (an_mag_q != '0), an_mag_q);
							state_q  <= S_FIN;
						end
						rau_pkg::CMD_ABS: begin
							rn_neg_q <= 1'b0;
							rn_mag_q <= an_mag_q;
							rd_mag_q <= ad_q;
							ovf_q    <= !rau_pkg::fits(1'b0, an_mag_q);
							state_q  <= S_FIN;
						end
						rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
							gx_q      <= ad_q;
							gy_q      <= bd_q;
							gcd_ret_q <= S_AS1;
							state_q   <= S_GCD;
						end
						rau_pkg::CMD_MUL: begin
							req_q     <= '{start: 1'b1, div: 1'b0, x: an_mag_q, y: bn_mag_q};
							alu_ret_q <= S_M1;
							state_q   <= S_WAIT;
						end
						rau_pkg::CMD_DIV: begin
							if (bn_mag_q == '0) begin
								bad_q   <= 1'b1;
								state_q <= S_FIN;
							end else begin
								req_q     <= '{start: 1'b1, div: 1'b0, x: an_mag_q, y: bd_q};
								alu_ret_q <= S_D1;
								state_q   <= S_WAIT;
							end
						end
						default: begin
							req_q     <= '{start: 1'b1, div: 1'b0, x: an_mag_q, y: bd_q};
							alu_ret_q <= S_C1;
							state_q   <= S_WAIT;
						end
					endcase
				end
				// add and subtract over the lcm of the denominators
				S_AS1: begin
					req_q     <= '{start: 1'b1, div: 1'b1, x: ad_q, y: gx_q};
					alu_ret_q <= S_AS2;
					state_q   <= S_WAIT;
				end
				S_AS2: begin
					req_q     <= '{start: 1'b1, div: 1'b0, x: prod, y: bd_q};
					alu_ret_q <= S_AS3;
					state_q   <= S_WAIT;
				end
				S_AS3: begin
					lcm_q <= prod;
					if (!fit_pos) begin
						ovf_q   <= 1'b1;
						state_q <= S_FIN;
					end else begin
						req_q     <= '{start: 1'b1, div: 1'b1, x: prod, y: ad_q};
						alu_ret_q <= S_AS4;
						state_q   <= S_WAIT;
					end
				end
				S_AS4: begin
					req_q     <= '{start: 1'b1, div: 1'b0, x: prod, y: an_mag_q};
					alu_ret_q <= S_AS5;
					state_q   <= S_WAIT;
				end
				S_AS5: begin
					x_neg_q <= an_neg_q && prod_nz;
					x_mag_q <= prod;
					if (!(an_neg_q ? fit_neg : fit_pos)) begin
						ovf_q   <= 1'b1;
						state_q <= S_FIN;
					end else begin
						req_q     <= '{start: 1'b1, div: 1'b1, x: lcm_q, y: bd_q};
						alu_ret_q <= S_AS6;
						state_q   <= S_WAIT;
					end
				end
				S_AS6: begin
					req_q     <= '{start: 1'b1, div: 1'b0, x: prod, y: bn_mag_q};
					alu_ret_q <= S_AS7;
					state_q   <= S_WAIT;
				end
				S_AS7: begin
					if (!(bn_neg_q ? fit_neg : fit_pos) || !sum_ok) begin
						ovf_q   <= 1'b1;
						state_q <= S_FIN;
					end else begin
						rn_neg_q  <= sum_neg;
						rn_mag_q  <= sum_mag;
						rd_neg_q  <= 1'b0;
						rd_mag_q  <= lcm_q;
						red_ret_q <= S_FIN;
						state_q   <= S_RED;
					end
				end
				// multiply
				S_M1: begin
					x_neg_q <= (an_neg_q ^ bn_neg_q) && prod_nz;
					x_mag_q <= prod;
					if (!((an_neg_q ^ bn_neg_q) ? fit_neg : fit_pos)) begin
						ovf_q   <= 1'b1;
						state_q <= S_FIN;
					end else begin
						req_q     <= '{start: 1'b1, div: 1'b0, x: ad_q, y: bd_q};
						alu_ret_q <= S_M2;
						state_q   <= S_WAIT;
					end
				end
				S_M2: begin
					if (!fit_pos) begin
						ovf_q   <= 1'b1;
						state_q <= S_FIN;
					end else begin
						rn_neg_q  <= x_neg_q;
						rn_mag_q  <= x_mag_q;
						rd_neg_q  <= 1'b0;
						rd_mag_q  <= prod;
						red_ret_q <= S_FIN;
						state_q   <= S_RED;
					end
				end
				// divide
				S_D1: begin
					x_neg_q <= an_neg_q && prod_nz;
					x_mag_q <= prod;
					if (!(an_neg_q ? fit_neg : fit_pos)) begin
						ovf_q   <= 1'b1;
						state_q <= S_FIN;
					end else begin
						req_q     <= '{start: 1'b1, div: 1'b0, x: ad_q, y: bn_mag_q};
						alu_ret_q <= S_D2;
						state_q   <= S_WAIT;
					end
				end
				S_D2: begin
					if (!(bn_neg_q ? fit_neg : fit_pos)) begin
						ovf_q   <= 1'b1;
						state_q <= S_FIN;
					end else begin
						rn_neg_q  <= x_neg_q;
						rn_mag_q  <= x_mag_q;
						rd_neg_q  <= bn_neg_q && prod_nz;
						rd_mag_q  <= prod;
						red_ret_q <= S_FIN;
						state_q   <= S_RED;
					end
				end
				// compare
				S_C1: begin
					x_neg_q <= an_neg_q && prod_nz;
					x_mag_q <= prod;
					if (!(an_neg_q ? fit_neg : fit_pos)) begin
						ovf_q   <= 1'b1;
						state_q <= S_FIN;
					end else begin
						req_q     <= '{start: 1'b1, div: 1'b0, x: bn_mag_q, y: ad_q};
						alu_ret_q <= S_C2;
						state_q   <= S_WAIT;
					end
				end
				S_C2: begin
					if (!(bn_neg_q ? fit_neg : fit_pos)) begin
						ovf_q <= 1'b1;
					end else begin
						less_q  <= cmp_less;
						equal_q <= (an_neg_q == bn_neg_q) && (an_mag_q == bn_mag_q)
							&& (ad_q == bd_q);
					end
					rn_neg_q <= 1'b0;
					rn_mag_q <= '0;
					rd_mag_q <= '0;
					state_q  <= S_FIN;
				end
				S_FIN: begin
					if (take) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// capture of the raw operand fields
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q    <= cmd;
			ra_num_q <= a_num;
			ra_den_q <= a_den;
			rb_num_q <= b_num;
			rb_den_q <= b_den;
		end
	end

	// result word, cleared on a flagged case
	always_comb begin
		res = '0;
		if (bad_q) begin
			res.bad = 1'b1;
		end else if (ovf_q) begin
			res.ovf = 1'b1;
		end else begin
			res.num   = rn_neg_q ? (~rn_mag_q + 1'b1) : rn_mag_q;
			res.den   = rd_mag_q[W-2:0];
			res.less  = less_q;
			res.equal = equal_q;
		end
	end

	assign req  = req_q;
	assign busy = state_q != S_IDLE;
	assign fin  = state_q == S_FIN;

endmodule

// ===== design/rational_arithmetic_unit.sv =====
// channel | direction | handshake           | payload
// in      | input     | in_valid, in_stall  | cmd, a_num, a_den, b_num, b_den
// out     | output    | out_valid, out_stall| res_num, res_den, less, equal, bad, overflow
//
// one word at a time: a single multiply/divide unit runs under the
// sequencer, gcd steps each cost one division
// a word with a flagged zero denominator skips all arithmetic; a gcd takes
// up to 92 euclid steps, and add/sub runs four gcds
// reset clears the sequencer and the output valid, no clearing pass
// in_stall is high while a word is in work; a finished word waits in the
// sequencer while the output register is stalled
module rational_arithmetic_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    cmd,
	input  logic [rau_pkg::WORD_BITS-1:0] a_num,
	input  logic [rau_pkg::WORD_BITS-1:0] a_den,
	input  logic [rau_pkg::WORD_BITS-1:0] b_num,
	input  logic [rau_pkg::WORD_BITS-1:0] b_den,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rau_pkg::WORD_BITS-1:0] res_num,
	output logic [rau_pkg::WORD_BITS-2:0] res_den,
	output logic                          less,
	output logic                          equal,
	output logic                          bad,
	output logic                          overflow
);

	rau_pkg::rau_req_t req;
	rau_pkg::rau_rsp_t rsp;
	rau_pkg::rau_res_t res;
	rau_pkg::rau_res_t out_q;
	logic              busy;
	logic              fin;
	logic              take;
	logic              out_valid_q;

	// output register is free when empty or being drained
	assign take     = !out_valid_q || !out_stall;
	assign in_stall = busy;

	rau_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	rau_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_valid && !busy),
		.cmd    (cmd),
		.a_num  (a_num),
		.a_den  (a_den),
		.b_num  (b_num),
		.b_den  (b_den),
		.take   (take),
		.rsp    (rsp),
		.req    (req),
		.busy   (busy),
		.fin    (fin),
		.res    (res)
	);

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= fin;
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (take && fin) out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign res_num   = out_q.num;
	assign res_den   = out_q.den;
	assign less      = out_q.less;
	assign equal     = out_q.equal;
	assign bad       = out_q.bad;
	assign overflow  = out_q.ovf;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam int N_RANDOM    = 930;
	localparam int HOLD_CYCLES = 3000;
	localparam longint LIMIT   = 150_000_000;
	localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAX_P   = 64'h7fff_ffff_ffff_ffff;

	// sign-magnitude value
	typedef struct {
		bit        neg;
		bit [63:0] mag;
	} smag_t;

	// expected results of accepted words, oldest first
	class rational_scoreboard;
		rau_pkg::rau_res_t pending_res[$];
		int       errors;

		function smag_t mk(bit neg, bit [63:0] mag);
			smag_t r;
			r.neg = neg && mag != 0;
			r.mag = mag;
			return r;
		endfunction

		function bit fits_w(smag_t v);
			return v.neg ? v.mag <= rau_pkg::HALF_W : v.mag <= rau_pkg::MAX_POS;
		endfunction

		function smag_t to_smag(bit [63:0] raw);
			return raw[63] ? mk(1'b1, -raw) : mk(1'b0, raw);
		endfunction

		function bit smul(smag_t a, smag_t b, output smag_t r);
			bit [127:0] p;
			p = a.mag * b.mag;
			r = mk(a.neg != b.neg, p[63:0]);
			return p[127:64] == 0 && fits_w(r);
		endfunction

		function bit sadd(smag_t a, smag_t b, output smag_t r);
			bit [64:0] s;
			if (a.neg == b.neg) begin
				s = a.mag + b.mag;
				if (s[64]) return 0;
				r = mk(a.neg, s[63:0]);
			end else if (a.mag >= b.mag) begin
				r = mk(a.neg, a.mag - b.mag);
			end else begin
				r = mk(b.neg, b.mag - a.mag);
			end
			return fits_w(r);
		endfunction

		function bit [63:0] gcd(bit [63:0] a, bit [63:0] b);
			bit [63:0] t;
			while (b != 0) begin
				t = a % b;
				a = b;
				b = t;
			end
			return a;
		endfunction

		// 0 ok, 1 zero denominator, 2 overflow
		function int lowest_terms(smag_t n, smag_t d, output smag_t rn, output bit [63:0] rd);
			bit [63:0] g;
			rn = mk(0, 0);
			rd = 0;
			if (d.mag == 0) return 1;
			g = gcd(n.mag, d.mag);
			rn = mk(n.neg != d.neg, n.mag / g);
			rd = d.mag / g;
			if (!fits_w(rn) || rd > rau_pkg::MAX_POS) return 2;
			return 0;
		endfunction

		// work out the result of one accepted word
		function void note_word(logic [2:0] c, logic [63:0] an_r, logic [63:0] ad_r,
				logic [63:0] bn_r, logic [63:0] bd_r);
			smag_t an, bn, rn, x, y, l, ta, tb, s;
			bit [63:0] ad, bd, rd, g;
			bit two_op, is_bad, ovf, lt, eq;
			int st;
			rau_pkg::rau_res_t e;
			two_op = (c >= rau_pkg::CMD_ADD && c <= rau_pkg::CMD_DIV) || c == rau_pkg::CMD_CMP;
			rn = mk(0, 0);
			rd = 0;
			ovf = 0;
			lt = 0;
			eq = 0;
			is_bad = to_smag(ad_r).mag == 0 || (two_op && to_smag(bd_r).mag == 0);
			if (!is_bad) begin
				if (lowest_terms(to_smag(an_r), to_smag(ad_r), an, ad) != 0) ovf = 1;
				if (two_op && lowest_terms(to_smag(bn_r), to_smag(bd_r), bn, bd) != 0) ovf = 1;
			end
			if (!is_bad && !ovf) begin
				case (c)
					rau_pkg::CMD_NORM: begin
						rn = an;
						rd = ad;
					end
					rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
						g = gcd(ad, bd);
						if (!smul(mk(0, ad / g), mk(0, bd), l) ||
								!smul(mk(0, l.mag / ad), an, ta) ||
								!smul(mk(0, l.mag / bd), bn, tb)) begin
							ovf = 1;
						end else begin
							if (c == rau_pkg::CMD_SUB) tb = mk(!tb.neg, tb.mag);
							if (!sadd(ta, tb, s)) ovf = 1;
							else if (lowest_terms(s, l, rn, rd) != 0) ovf = 1;
						end
					end
					rau_pkg::CMD_MUL: begin
						if (!smul(an, bn, x) || !smul(mk(0, ad), mk(0, bd), y)) ovf = 1;
						else if (lowest_terms(x, y, rn, rd) != 0) ovf = 1;
					end
					rau_pkg::CMD_DIV: begin
						if (bn.mag == 0) is_bad = 1;
						else if (!smul(an, mk(0, bd), x) || !smul(mk(0, ad), bn, y)) ovf = 1;
						else begin
							st = lowest_terms(x, y, rn, rd);
							if (st == 1) is_bad = 1;
							else if (st == 2) ovf = 1;
						end
					end
					rau_pkg::CMD_NEG: begin
						rn = mk(!an.neg, an.mag);
						rd = ad;
						if (!fits_w(rn)) ovf = 1;
					end
					rau_pkg::CMD_ABS: begin
						rn = mk(0, an.mag);
						rd = ad;
						if (!fits_w(rn)) ovf = 1;
					end
					default: begin
						if (!smul(an, mk(0, bd), x) || !smul(bn, mk(0, ad), y)) begin
							ovf = 1;
						end else begin
							if (x.neg != y.neg) lt = x.neg;
							else if (x.neg) lt = x.mag > y.mag;
							else lt = x.mag < y.mag;
							eq = an.neg == bn.neg && an.mag == bn.mag && ad == bd;
							rn = mk(0, 0);
							rd = 0;
						end
					end
				endcase
			end
			if (is_bad) ovf = 0;
			if (is_bad || ovf) begin
				rn = mk(0, 0);
				rd = 0;
				lt = 0;
				eq = 0;
			end
			e.num = rn.neg ? -rn.mag : rn.mag;
			e.den = rd[62:0];
			e.less = lt;
			e.equal = eq;
			e.bad = is_bad;
			e.ovf = ovf;
			pending_res.push_back(e);
		endfunction

		// compare one accepted result with the oldest expectation
		function void check_word(rau_pkg::rau_res_t got);
			rau_pkg::rau_res_t e;
			if (pending_res.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
				return;
			end
			e = pending_res.pop_front();
			if (got.num !== e.num) begin
				$error("res_num: expected %h actual %h", e.num, got.num);
				errors++;
			end
			if (got.den !== e.den) begin
				$error("res_den: expected %h actual %h", e.den, got.den);
				errors++;
			end
			if (got.less !== e.less) begin
				$error("less: expected %b actual %b", e.less, got.less);
				errors++;
			end
			if (got.equal !== e.equal) begin
				$error("equal: expected %b actual %b", e.equal, got.equal);
				errors++;
			end
			if (got.bad !== e.bad) begin
				$error("bad: expected %b actual %b", e.bad, got.bad);
				errors++;
			end
			if (got.ovf !== e.ovf) begin
				$error("overflow: expected %b actual %b", e.ovf, got.ovf);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [2:0] cmd = rau_pkg::CMD_NORM;
	logic [63:0] a_num = 0, a_den = 0, b_num = 0, b_den = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [63:0] res_num;
	logic [62:0] res_den;
	logic less, equal, bad, overflow;

	rational_scoreboard sb = new();
	bit quiet = 0;
	bit hold_req = 0;
	longint cycles = 0;

	rational_arithmetic_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.out_valid(out_valid), .out_stall(out_stall),
		.res_num(res_num), .res_den(res_den),
		.less(less), .equal(equal), .bad(bad), .overflow(overflow)
	);

	always #2 clk = ~clk;

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result side: check accepted words, stall in bursts or one long hold
	initial begin
		int burst;
		int hold_left;
		rau_pkg::rau_res_t got;
		burst = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got.num = res_num;
				got.den = res_den;
				got.less = less;
				got.equal = equal;
				got.bad = bad;
				got.ovf = overflow;
				sb.check_word(got);
			end
			if (hold_req) begin
				hold_req = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1;
			end else if (quiet) begin
				burst = 0;
				out_stall <= 0;
			end else if (burst > 0) begin
				burst--;
				out_stall <= 1;
			end else if ($urandom_range(0, 5) == 0) begin
				burst = $urandom_range(0, 6);
				out_stall <= 1;
			end else begin
				out_stall <= 0;
			end
		end
	end

	// offer one word and wait until it is taken
	task automatic send_word(logic [2:0] c, logic [63:0] an, logic [63:0] ad,
			logic [63:0] bn, logic [63:0] bd);
		in_valid <= 1;
		cmd <= c;
		a_num <= an;
		a_den <= ad;
		b_num <= bn;
		b_den <= bd;
		do @(posedge clk); while (in_stall);
		sb.note_word(c, an, ad, bn, bd);
	endtask

	task automatic maybe_gap();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	function automatic logic [63:0] rnd_val();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: rnd_val = 64'($signed($urandom_range(0, 255)) - 128);
			5, 6, 7: rnd_val = {{32{$urandom_range(0, 1) == 1}}, 32'($urandom)};
			8: rnd_val = {32'($urandom), 32'($urandom)};
			default: begin
				case ($urandom_range(0, 4))
					0: rnd_val = 0;
					1: rnd_val = 1;
					2: rnd_val = '1;
					3: rnd_val = MAX_P;
					default: rnd_val = MIN_NEG;
				endcase
			end
		endcase
	endfunction

	function automatic logic [63:0] rnd_den();
		if ($urandom_range(0, 29) == 0) return 0;
		return rnd_val();
	endfunction

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed words
		send_word(rau_pkg::CMD_NORM, 6, -4, 0, 0);
		send_word(rau_pkg::CMD_NORM, 0, 0, 0, 0);
		send_word(rau_pkg::CMD_NORM, MIN_NEG, -1, 0, 0);
		send_word(rau_pkg::CMD_NORM, 3, MIN_NEG, 0, 0);
		send_word(rau_pkg::CMD_NORM, MAX_P, MAX_P, 5, 0);
		send_word(rau_pkg::CMD_ADD, 1, 2, 1, 3);
		send_word(rau_pkg::CMD_ADD, 1, 0, 1, 3);
		send_word(rau_pkg::CMD_ADD, MAX_P, 1, 1, 1);
		send_word(rau_pkg::CMD_SUB, 1, 6, 1, 10);
		send_word(rau_pkg::CMD_SUB, MIN_NEG, 1, 1, 1);
		send_word(rau_pkg::CMD_MUL, 2, 3, 9, 4);
		send_word(rau_pkg::CMD_MUL, MAX_P, 1, 2, 1);
		send_word(rau_pkg::CMD_MUL, 5, 7, 3, 0);
		send_word(rau_pkg::CMD_DIV, 1, 2, 3, 4);
		send_word(rau_pkg::CMD_DIV, 1, 2, 0, 5);
		send_word(rau_pkg::CMD_DIV, MIN_NEG, 1, 1, 2);
		send_word(rau_pkg::CMD_NEG, -3, 9, 0, 0);
		send_word(rau_pkg::CMD_NEG, MIN_NEG, 1, 0, 0);
		send_word(rau_pkg::CMD_ABS, -7, -2, 0, 0);
		send_word(rau_pkg::CMD_ABS, MIN_NEG, 1, 0, 0);
		send_word(rau_pkg::CMD_CMP, 1, 2, 2, 4);
		send_word(rau_pkg::CMD_CMP, -1, 3, 1, 3);
		send_word(rau_pkg::CMD_CMP, MAX_P, 1, MIN_NEG, 1);
		send_word(rau_pkg::CMD_CMP, 1, 2, 1, 0);

		// random words, with a long result hold and a full drain on the way
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 200) hold_req = 1;
			if (i == 450) begin
				in_valid <= 0;
				do @(posedge clk); while (sb.pending_res.size() != 0);
			end
			if (i == N_RANDOM - 120) quiet = 1;
			send_word(3'($urandom_range(0, 7)), rnd_val(), rnd_den(), rnd_val(), rnd_den());
			maybe_gap();
		end
		in_valid <= 0;

		// drain
		do @(posedge clk); while (sb.pending_res.size() != 0);
		repeat (100) @(posedge clk);
		if (sb.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
